FILE: src/pbcs_pkg.sv
// Shared types and constants of the page buffer clock-sweep pool.
package pbcs_pkg;

   localparam int ID_W        = 32;
   localparam int SLOT_OUT_W  = 4;
   localparam int USAGE_W     = 3;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = 5;
   localparam int SWEEP_PASSES = 2;
   localparam logic [USAGE_W-1:0] USAGE_MAX = 3'd5;

   // Request kinds
   typedef enum logic [1:0] {
      MODE_LOOKUP  = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_FLUSH   = 2'd2,
      MODE_EVICT   = 2'd3
   } mode_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LK_SCAN,
      ST_HIT,
      ST_SWEEP,
      ST_VIC_RD,
      ST_VIC_WR,
      ST_REL,
      ST_FL_RD,
      ST_FL_CHK,
      ST_FL_END
   } state_type;

   // Page tag as stored in the tag RAM
   typedef struct packed {
      logic [ID_W-1:0] database;
      logic [ID_W-1:0] relation;
      logic [ID_W-1:0] relnode;
      logic [ID_W-1:0] page;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

   // Operations on the per-slot valid, dirty and usage state
   typedef enum logic [2:0] {
      SOP_NONE,
      SOP_INC,
      SOP_DEC,
      SOP_INSTALL,
      SOP_SET_DIRTY,
      SOP_CLEAN,
      SOP_EVICT
   } slot_op_type;

   typedef struct packed {
      slot_op_type op;
      logic        dirty;
   } slot_cmd_type;

   typedef struct packed {
      logic               valid;
      logic               dirty;
      logic [USAGE_W-1:0] usage;
   } slot_stat_type;

   // One result item
   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      logic                  hit;
      logic                  found;
      logic                  write_back;
      tag_type               wb;
      logic                  last;
   } rsp_type;

endpackage

FILE: src/pbcs_if.sv
// Request and result channel interfaces of the page buffer pool.
interface pbcs_req_if
   import pbcs_pkg::*;
();
   logic            valid;
   logic            ready;
   mode_type        mode;
   logic [ID_W-1:0] database_id;
   logic [ID_W-1:0] relation_id;
   logic [ID_W-1:0] relnode_id;
   logic [ID_W-1:0] page_number;
   logic            page_exists;
   logic [3:0]      release_slot;
   logic            mark_dirty;

   modport source (
      output valid, mode, database_id, relation_id, relnode_id, page_number,
             page_exists, release_slot, mark_dirty,
      input  ready
   );
   modport sink (
      input  valid, mode, database_id, relation_id, relnode_id, page_number,
             page_exists, release_slot, mark_dirty,
      output ready
   );
endinterface

interface pbcs_rsp_if
   import pbcs_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [SLOT_OUT_W-1:0] slot;
   logic                  hit;
   logic                  found;
   logic                  write_back;
   logic [ID_W-1:0]       wb_database;
   logic [ID_W-1:0]       wb_relation;
   logic [ID_W-1:0]       wb_relnode;
   logic [ID_W-1:0]       wb_page;
   logic                  last;

   modport source (
      output valid, slot, hit, found, write_back, wb_database, wb_relation,
             wb_relnode, wb_page, last,
      input  ready
   );
   modport sink (
      input  valid, slot, hit, found, write_back, wb_database, wb_relation,
             wb_relnode, wb_page, last,
      output ready
   );
endinterface

FILE: src/pbcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbcs_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pbcs_slot_state.sv
// Per-slot valid, dirty and usage-count state with a single-slot update port.
module pbcs_slot_state
   import pbcs_pkg::*;
#(
   parameter int SLOTS = 16,
   localparam int SW = $clog2(SLOTS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [SW-1:0] addr,
   input  slot_cmd_type  cmd,
   output slot_stat_type stat
);

   logic [SLOTS-1:0]              valid_ff, valid_in;
   logic [SLOTS-1:0]              dirty_ff, dirty_in;
   logic [SLOTS-1:0][USAGE_W-1:0] usage_ff, usage_in;

   // Read the addressed slot
   assign stat.valid = valid_ff[addr];
   assign stat.dirty = dirty_ff[addr];
   assign stat.usage = usage_ff[addr];

   // Apply the command to the addressed slot
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      usage_in = usage_ff;
      unique case (cmd.op)
         SOP_NONE: ;
         SOP_INC: begin
            if (usage_ff[addr] < USAGE_MAX) begin
               usage_in[addr] = usage_ff[addr] + 1'b1;
            end
         end
         SOP_DEC: usage_in[addr] = usage_ff[addr] - 1'b1;
         SOP_INSTALL: begin
            valid_in[addr] = 1'b1;
            dirty_in[addr] = cmd.dirty;
            usage_in[addr] = USAGE_W'(1);
         end
         SOP_SET_DIRTY: dirty_in[addr] = 1'b1;
         SOP_CLEAN:     dirty_in[addr] = 1'b0;
         SOP_EVICT: begin
            valid_in[addr] = 1'b0;
            dirty_in[addr] = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         usage_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         usage_ff <= usage_in;
      end
   end

endmodule

FILE: src/page_buffer_clock_sweep.sv
// Top level of the page buffer pool with clock-sweep replacement.
//
// One request is taken at a time; req ready is high only while the sequencer
// is idle, and a finished result may still wait in the output register.
// A lookup compares one stored tag per cycle out of the tag RAM's single read
// port and stops at the first matching slot; a miss first compares every slot,
// then runs the clock sweep (one slot per cycle) for at most SWEEP_PASSES
// passes, then reads the victim tag and installs the new one. Flush and evict
// read and check each slot in turn, and one result leaves per write-back
// reported, or a single empty last result if there is none. The hit, victim
// install, release and flush steps stall while the result side does not take
// a waiting result.
module page_buffer_clock_sweep
   import pbcs_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic   clock,
   input  logic   reset,
   pbcs_req_if.sink   req_chan,
   pbcs_rsp_if.source rsp_chan
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SWEEP_PASSES * SLOTS);
   localparam logic [SW-1:0] LAST_SLOT  = SW'(SLOTS - 1);
   localparam logic [CW-1:0] SWEEP_LAST = CW'(SWEEP_PASSES * SLOTS - 1);

   state_type state_ff, state_in;

   // Captured request
   mode_type   mode_ff, mode_in;
   tag_type    key_ff, key_in;
   logic       exists_ff, exists_in;
   logic [3:0] rslot_ff, rslot_in;
   logic       mdirty_ff, mdirty_in;

   // Sequencer datapath
   logic [SW-1:0]        idx_ff, idx_in;
   logic [SW-1:0]        cmp_ff, cmp_in;
   logic                 pend_ff, pend_in;
   logic [SW-1:0]        hand_ff, hand_in;
   logic [CW-1:0]        sweep_ff, sweep_in;
   logic [RES_CNT_W-1:0] nres_ff, nres_in;
   rsp_type              held_ff, held_in;
   logic                 held_v_ff, held_v_in;
   rsp_type              out_ff, out_in;
   logic                 out_v_ff, out_v_in;

   // Control
   logic          accept, out_free, out_load;
   rsp_type       out_next;
   logic [SW-1:0] ss_addr;
   slot_cmd_type  ss_cmd;
   slot_stat_type st;
   logic          ram_we;
   logic [TAG_W-1:0] rd_raw;
   tag_type       rd_tag;

   logic tbl_eq, lk_hit, lk_miss_end, sw_take, sw_end;
   logic fl_match, fl_emit, fl_go, rel_ok;

   // Tag store
   pbcs_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_raw)
   );

   assign rd_tag = tag_type'(rd_raw);

   // Slot flags and usage counts
   pbcs_slot_state #(.SLOTS(SLOTS)) u_slot_state (
      .clock (clock),
      .reset (reset),
      .addr  (ss_addr),
      .cmd   (ss_cmd),
      .stat  (st)
   );

   // Handshake and condition terms
   assign accept   = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free = !out_v_ff || rsp_chan.ready;

   assign tbl_eq = (rd_tag.database == key_ff.database) &&
                   (rd_tag.relation == key_ff.relation) &&
                   (rd_tag.relnode  == key_ff.relnode);
   assign lk_hit      = pend_ff && st.valid && tbl_eq && (rd_tag.page == key_ff.page);
   assign lk_miss_end = pend_ff && !lk_hit && (cmp_ff == LAST_SLOT);
   assign sw_take     = !st.valid || (st.usage == '0);
   assign sw_end      = (sweep_ff == SWEEP_LAST);
   assign fl_match    = st.valid && tbl_eq;
   assign fl_emit     = fl_match && st.dirty && (nres_ff < RES_CNT_W'(MAX_RESULTS));
   assign fl_go       = !fl_emit || !held_v_ff || out_free;
   assign rel_ok      = (int'(rslot_ff) < SLOTS);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.mode)
                  MODE_LOOKUP:            state_in = ST_LK_SCAN;
                  MODE_RELEASE:           state_in = ST_REL;
                  MODE_FLUSH, MODE_EVICT: state_in = ST_FL_RD;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_LK_SCAN: begin
            if (lk_hit) begin
               state_in = ST_HIT;
            end else if (lk_miss_end) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sw_take || sw_end) begin
               state_in = ST_VIC_RD;
            end
         end
         ST_VIC_RD: state_in = ST_VIC_WR;
         ST_HIT, ST_VIC_WR, ST_REL, ST_FL_END: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FL_RD: state_in = ST_FL_CHK;
         ST_FL_CHK: begin
            if (fl_go) begin
               state_in = (idx_ff == LAST_SLOT) ? ST_FL_END : ST_FL_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Slot commands, RAM write and result load
   always_comb begin
      ss_addr      = idx_ff;
      ss_cmd.op    = SOP_NONE;
      ss_cmd.dirty = !exists_ff;
      ram_we       = 1'b0;
      out_load     = 1'b0;
      out_next     = '0;
      out_next.last = 1'b1;
      unique case (state_ff)
         ST_LK_SCAN: ss_addr = cmp_ff;
         ST_HIT: begin
            if (out_free) begin
               ss_cmd.op           = SOP_INC;
               out_load            = 1'b1;
               out_next.slot       = SLOT_OUT_W'(idx_ff);
               out_next.hit        = 1'b1;
               out_next.found      = 1'b1;
            end
         end
         ST_SWEEP: begin
            ss_addr = hand_ff;
            if (!sw_take) begin
               ss_cmd.op = SOP_DEC;
            end
         end
         ST_VIC_WR: begin
            if (out_free) begin
               ss_cmd.op           = SOP_INSTALL;
               ram_we              = 1'b1;
               out_load            = 1'b1;
               out_next.slot       = SLOT_OUT_W'(idx_ff);
               out_next.found      = exists_ff;
               out_next.write_back = st.valid && st.dirty;
               if (st.valid && st.dirty) begin
                  out_next.wb = rd_tag;
               end
            end
         end
         ST_REL: begin
            ss_addr = SW'(rslot_ff);
            if (out_free) begin
               if (rel_ok && mdirty_ff) begin
                  ss_cmd.op = SOP_SET_DIRTY;
               end
               out_load      = 1'b1;
               out_next.slot = rslot_ff;
            end
         end
         ST_FL_CHK: begin
            if (fl_go) begin
               // Keep a dirty page that no longer fits in the results
               if (fl_match && (mode_ff == MODE_EVICT) && (fl_emit || !st.dirty)) begin
                  ss_cmd.op = SOP_EVICT;
               end else if (fl_emit) begin
                  ss_cmd.op = SOP_CLEAN;
               end
               if (fl_emit && held_v_ff) begin
                  out_load = 1'b1;
                  out_next = held_ff;
               end
            end
         end
         ST_FL_END: begin
            if (out_free) begin
               out_load = 1'b1;
               if (held_v_ff) begin
                  out_next      = held_ff;
                  out_next.last = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      mode_in   = mode_ff;
      key_in    = key_ff;
      exists_in = exists_ff;
      rslot_in  = rslot_ff;
      mdirty_in = mdirty_ff;
      idx_in    = idx_ff;
      cmp_in    = cmp_ff;
      pend_in   = pend_ff;
      hand_in   = hand_ff;
      sweep_in  = sweep_ff;
      nres_in   = nres_ff;
      held_in   = held_ff;
      held_v_in = held_v_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in         = req_chan.mode;
               key_in.database = req_chan.database_id;
               key_in.relation = req_chan.relation_id;
               key_in.relnode  = req_chan.relnode_id;
               key_in.page     = req_chan.page_number;
               exists_in       = req_chan.page_exists;
               rslot_in        = req_chan.release_slot;
               mdirty_in       = req_chan.mark_dirty;
               idx_in          = '0;
               pend_in         = 1'b0;
               nres_in         = '0;
               held_v_in       = 1'b0;
            end
         end
         ST_LK_SCAN: begin
            // Issue the next tag read while comparing the previous one
            cmp_in  = idx_ff;
            pend_in = 1'b1;
            if (idx_ff != LAST_SLOT) begin
               idx_in = idx_ff + 1'b1;
            end
            if (lk_hit) begin
               idx_in = cmp_ff;
            end
            sweep_in = '0;
         end
         ST_SWEEP: begin
            // Advance the hand one slot a cycle
            hand_in = (hand_ff == LAST_SLOT) ? '0 : hand_ff + 1'b1;
            if (sw_take) begin
               idx_in = hand_ff;
            end else if (sw_end) begin
               idx_in = '0;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_FL_CHK: begin
            if (fl_go) begin
               if (fl_emit) begin
                  held_in.slot       = SLOT_OUT_W'(idx_ff);
                  held_in.hit        = 1'b0;
                  held_in.found      = 1'b0;
                  held_in.write_back = 1'b1;
                  held_in.wb         = rd_tag;
                  held_in.last       = 1'b0;
                  held_v_in          = 1'b1;
                  nres_in            = nres_ff + 1'b1;
               end
               if (idx_ff != LAST_SLOT) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Output register
   always_comb begin
      out_in   = out_ff;
      out_v_in = out_v_ff;
      if (out_load) begin
         out_in   = out_next;
         out_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         hand_ff   <= '0;
         pend_ff   <= 1'b0;
         held_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         nres_ff   <= '0;
         sweep_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         hand_ff   <= hand_in;
         pend_ff   <= pend_in;
         held_v_ff <= held_v_in;
         out_v_ff  <= out_v_in;
         nres_ff   <= nres_in;
         sweep_ff  <= sweep_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      exists_ff <= exists_in;
      rslot_ff  <= rslot_in;
      mdirty_ff <= mdirty_in;
      idx_ff    <= idx_in;
      cmp_ff    <= cmp_in;
      held_ff   <= held_in;
      out_ff    <= out_in;
   end

   // Drive the channels
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.slot        = out_ff.slot;
   assign rsp_chan.hit         = out_ff.hit;
   assign rsp_chan.found       = out_ff.found;
   assign rsp_chan.write_back  = out_ff.write_back;
   assign rsp_chan.wb_database = out_ff.wb.database;
   assign rsp_chan.wb_relation = out_ff.wb.relation;
   assign rsp_chan.wb_relnode  = out_ff.wb.relnode;
   assign rsp_chan.wb_page     = out_ff.wb.page;
   assign rsp_chan.last        = out_ff.last;

endmodule
